// ===== hdl/cpm_pkg.sv =====
// ----------------------------------------------------------------------------
// cpm_pkg: shared definitions for the CIGAR position map
// Map geometry, epoch tagging, command, operation and register codes, and
// the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package cpm_pkg;

  // Map geometry.
  localparam int MAP_DEPTH = 4096;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);

  // Cursor and stored value widths.
  localparam int CURSOR_W = 17;
  localparam int VALUE_W  = 16;

  // Every map word carries the epoch of the start that wrote it. Epoch zero
  // is what the clearing pass writes and never matches a live walk.
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = '0;
  localparam int WORD_W = EPOCH_W + VALUE_W;

  // Request commands.
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_OP    = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } command_t;

  // CIGAR operation codes.
  localparam logic [3:0] OP_M  = 4'd0;
  localparam logic [3:0] OP_I  = 4'd1;
  localparam logic [3:0] OP_D  = 4'd2;
  localparam logic [3:0] OP_N  = 4'd3;
  localparam logic [3:0] OP_S  = 4'd4;
  localparam logic [3:0] OP_H  = 4'd5;
  localparam logic [3:0] OP_EQ = 4'd7;
  localparam logic [3:0] OP_X  = 4'd8;

  // Configuration register indexes.
  localparam logic [1:0] REG_ALIGN_START  = 2'd0;
  localparam logic [1:0] REG_REGION_LEN_A = 2'd1;
  localparam logic [1:0] REG_REGION_LEN_B = 2'd2;
  localparam logic [1:0] REG_REVERSE_B    = 2'd3;

  // Controller states.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SWEEP  = 5'b00010,
    S_WALK   = 5'b00100,
    S_LOOKUP = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/cigar_position_map.sv =====
// ----------------------------------------------------------------------------
// cigar_position_map: reference-to-read position map built from CIGAR runs
// Walks CIGAR operations, records the read position of each matched
// reference position and answers lookups into the map.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in channel (valid/ready) and each one produces
//   exactly one result on the out channel (valid/ready). Registers are to
//   be set through the APB port only while the block is idle; the block
//   itself does not enforce this. A start, a non-match operation and an
//   unused command go from the accepting edge straight to the finishing
//   state. A lookup reads the map on the accepting edge and forms the
//   value on the next. A match operation walks its map entries before it
//   finishes, the single write port writing one base a cycle.
//   in_ready rises together with out_valid, so the block takes no new
//   request before it is through with the last one.
//   Clearing the map does not touch the memory: each word is tagged with the
//   epoch of the start that wrote it, and only the current epoch is mapped.
//   Every 255th start the epoch wraps and a clearing pass rewrites all 4096
//   words before the result of that start is raised.
//   After reset the same clearing pass runs with in_ready low; register
//   writes are taken throughout.
//   The result register frees the controller: the next request is accepted
//   while an earlier result still waits on a stalled receiver, and that
//   request finishes only once the waiting result has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module cigar_position_map (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request channel.
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [3:0]  op_kind,
  input  wire logic [15:0] op_len,
  input  wire logic [11:0] entry_index,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [16:0] map_value,
  output logic             is_mapped,
  output logic             overrun,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int AW = cpm_pkg::ADDR_W;
  localparam int CW = cpm_pkg::CURSOR_W;
  localparam int VW = cpm_pkg::VALUE_W;
  localparam int EW = cpm_pkg::EPOCH_W;

  // Configuration registers.
  logic [12:0] align_start;
  logic [12:0] region_len_a;
  logic [15:0] region_len_b;
  logic        reverse_b;

  // Walk state.
  cpm_pkg::state_t state;
  logic [CW-1:0]   ref_cursor;
  logic [CW-1:0]   read_cursor;
  logic            overrun_seen;
  logic [EW-1:0]   epoch;
  logic            sweep_reply;
  logic [AW-1:0]   sweep_addr;
  logic [CW-1:0]   walk_pos;
  logic [CW-1:0]   walk_end;
  logic [VW-1:0]   walk_value;
  logic            index_ok;

  // Pending result.
  logic [16:0] res_value;
  logic        res_mapped;

  // Memory interface.
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [cpm_pkg::WORD_W-1:0] mem_wdata;
  logic                      mem_re;
  logic [cpm_pkg::WORD_W-1:0] mem_rdata;

  logic            accept;
  cpm_pkg::command_t cmd;
  logic [CW-1:0]   map_limit;
  logic [CW:0]     ref_sum;
  logic [CW:0]     read_sum;
  logic [CW-1:0]   ref_sat;
  logic [CW-1:0]   read_sat;
  logic [CW:0]     match_end;
  logic [CW-1:0]   match_stop;
  logic [VW-1:0]   read_start;
  logic            out_free;
  logic            lookup_hit;
  logic [VW-1:0]   lookup_value;
  logic [16:0]     lookup_result;
  logic            cfg_write;

  assign pready    = 1'b1;
  assign in_ready  = (state == cpm_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign cmd       = cpm_pkg::command_t'(command);
  assign out_free  = !out_valid || out_ready;
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration writes and read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      align_start  <= 13'd1;
      region_len_a <= '0;
      region_len_b <= '0;
      reverse_b    <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        cpm_pkg::REG_ALIGN_START:  align_start  <= pwdata[12:0];
        cpm_pkg::REG_REGION_LEN_A: region_len_a <= pwdata[12:0];
        cpm_pkg::REG_REGION_LEN_B: region_len_b <= pwdata[15:0];
        cpm_pkg::REG_REVERSE_B:    reverse_b    <= pwdata[0];
        default:                   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      cpm_pkg::REG_ALIGN_START:  prdata = {19'd0, align_start};
      cpm_pkg::REG_REGION_LEN_A: prdata = {19'd0, region_len_a};
      cpm_pkg::REG_REGION_LEN_B: prdata = {16'd0, region_len_b};
      cpm_pkg::REG_REVERSE_B:    prdata = {31'd0, reverse_b};
      default:                   prdata = '0;
    endcase
  end

  // Cursor arithmetic for an incoming operation, saturating at the cursor
  // maximum.
  always_comb begin
    map_limit = (CW'(region_len_a) > CW'(cpm_pkg::MAP_DEPTH)) ?
                CW'(cpm_pkg::MAP_DEPTH) : CW'(region_len_a);
    ref_sum   = {1'b0, ref_cursor} + (CW+1)'(op_len);
    read_sum  = {1'b0, read_cursor} + (CW+1)'(op_len);
    ref_sat   = ref_sum[CW] ? {CW{1'b1}} : ref_sum[CW-1:0];
    read_sat  = read_sum[CW] ? {CW{1'b1}} : read_sum[CW-1:0];
    match_end = ref_sum;
    match_stop = (match_end < (CW+1)'(map_limit)) ? match_end[CW-1:0] : map_limit;
    read_start = (read_cursor > CW'({VW{1'b1}})) ? {VW{1'b1}} : read_cursor[VW-1:0];
  end

  // Lookup result formed from the word read out of the map.
  always_comb begin
    lookup_value  = mem_rdata[VW-1:0];
    lookup_hit    = index_ok && (mem_rdata[cpm_pkg::WORD_W-1:VW] == epoch);
    if (!lookup_hit) begin
      lookup_result = {17{1'b1}};
    end else if (reverse_b) begin
      lookup_result = 17'(region_len_b) - 17'(lookup_value) - 17'd1;
    end else begin
      lookup_result = 17'(lookup_value);
    end
  end

  // Memory port control: the sweep clears, the walk writes one base a cycle,
  // a lookup request reads.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_addr;
    mem_wdata = {cpm_pkg::EPOCH_CLEAR, {VW{1'b0}}};
    if (state == cpm_pkg::S_SWEEP) begin
      mem_we = 1'b1;
    end else if (state == cpm_pkg::S_WALK && walk_pos < walk_end) begin
      mem_we    = 1'b1;
      mem_waddr = walk_pos[AW-1:0];
      mem_wdata = {epoch, walk_value};
    end
    mem_re = accept && (cmd == cpm_pkg::CMD_READ);
  end

  // Controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= cpm_pkg::S_SWEEP;
      sweep_reply  <= 1'b0;
      sweep_addr   <= '0;
      epoch        <= cpm_pkg::EPOCH_FIRST;
      ref_cursor   <= '0;
      read_cursor  <= '0;
      overrun_seen <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // A finished request raises the result; a taken result drops it.
      if (state == cpm_pkg::S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        cpm_pkg::S_IDLE: begin
          if (accept) begin
            res_value  <= '0;
            res_mapped <= 1'b0;
            unique case (cmd)
              cpm_pkg::CMD_START: begin
                ref_cursor   <= (align_start != '0) ? CW'(align_start - 13'd1) : '0;
                read_cursor  <= '0;
                overrun_seen <= 1'b0;
                if (epoch == cpm_pkg::EPOCH_LAST) begin
                  epoch       <= cpm_pkg::EPOCH_FIRST;
                  sweep_addr  <= '0;
                  sweep_reply <= 1'b1;
                  state       <= cpm_pkg::S_SWEEP;
                end else begin
                  epoch <= epoch + EW'(1);
                  state <= cpm_pkg::S_FIN;
                end
              end
              cpm_pkg::CMD_OP: begin
                unique case (op_kind)
                  cpm_pkg::OP_I, cpm_pkg::OP_S, cpm_pkg::OP_H: begin
                    read_cursor <= read_sat;
                    state       <= cpm_pkg::S_FIN;
                  end
                  cpm_pkg::OP_D, cpm_pkg::OP_N: begin
                    ref_cursor <= ref_sat;
                    state      <= cpm_pkg::S_FIN;
                  end
                  cpm_pkg::OP_M, cpm_pkg::OP_EQ, cpm_pkg::OP_X: begin
                    if (op_len != '0) begin
                      if (match_end > (CW+1)'(map_limit)) begin
                        overrun_seen <= 1'b1;
                      end
                      walk_pos    <= ref_cursor;
                      walk_end    <= match_stop;
                      walk_value  <= read_start;
                      ref_cursor  <= ref_sat;
                      read_cursor <= read_sat;
                      state       <= cpm_pkg::S_WALK;
                    end else begin
                      state <= cpm_pkg::S_FIN;
                    end
                  end
                  default: state <= cpm_pkg::S_FIN;
                endcase
              end
              cpm_pkg::CMD_READ: begin
                index_ok <= (32'(entry_index) < cpm_pkg::MAP_DEPTH);
                state    <= cpm_pkg::S_LOOKUP;
              end
              default: state <= cpm_pkg::S_FIN;
            endcase
          end
        end
        cpm_pkg::S_SWEEP: begin
          sweep_addr <= sweep_addr + AW'(1);
          if (sweep_addr == AW'(cpm_pkg::MAP_DEPTH - 1)) begin
            state <= sweep_reply ? cpm_pkg::S_FIN : cpm_pkg::S_IDLE;
          end
        end
        cpm_pkg::S_WALK: begin
          if (walk_pos < walk_end) begin
            walk_pos <= walk_pos + CW'(1);
            if (walk_value != {VW{1'b1}}) begin
              walk_value <= walk_value + VW'(1);
            end
          end else begin
            state <= cpm_pkg::S_FIN;
          end
        end
        cpm_pkg::S_LOOKUP: begin
          res_value  <= lookup_result;
          res_mapped <= lookup_hit;
          state      <= cpm_pkg::S_FIN;
        end
        cpm_pkg::S_FIN: begin
          if (out_free) begin
            state <= cpm_pkg::S_IDLE;
          end
        end
        default: state <= cpm_pkg::S_IDLE;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state == cpm_pkg::S_FIN && out_free) begin
      map_value <= res_value;
      is_mapped <= res_mapped;
      overrun   <= overrun_seen;
    end
  end

  cpm_map_ram #(
    .DEPTH (cpm_pkg::MAP_DEPTH),
    .WIDTH (cpm_pkg::WORD_W)
  ) u_map_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (AW'(entry_index)),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== hdl/cpm_map_ram.sv =====
// ----------------------------------------------------------------------------
// cpm_map_ram: map memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cpm_map_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 24
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cpm_checker.sv =====
// ----------------------------------------------------------------------------
// cpm_checker: port-level checks for the CIGAR position map
// Watches the request, result and reset behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module cpm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [16:0] map_value,
  input wire logic        is_mapped
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(map_value))
    else $error("result changed while stalled");

  // An unmapped result is either zero or minus one.
  a_unmapped_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_mapped |-> map_value == 17'h00000 || map_value == 17'h1FFFF)
    else $error("unmapped result carries a position");

  // One request at a time: the block is busy right after accepting.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // Reset starts the clearing pass with no result pending.
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("block not busy after reset");

endmodule

bind cigar_position_map cpm_checker u_cpm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .map_value (map_value),
  .is_mapped (is_mapped)
);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the CIGAR position map
// Drives start, CIGAR operation and lookup requests under random idling and
// result stalls, predicts every answer from an independent model of the map
// walk, and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CURSOR_MAX = 131071;
  localparam int unsigned VALUE_MAX  = 65535;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS   = 10;

  // Operation codes that the package leaves unnamed.
  localparam logic [3:0] OP_P            = 4'd6;
  localparam logic [3:0] OP_UNKNOWN_LOW  = 4'd9;
  localparam logic [3:0] OP_UNKNOWN_HIGH = 4'd15;

  localparam logic [3:0] MATCH_KINDS [3] = '{cpm_pkg::OP_M, cpm_pkg::OP_EQ, cpm_pkg::OP_X};
  localparam logic [3:0] READ_KINDS  [3] = '{cpm_pkg::OP_I, cpm_pkg::OP_S, cpm_pkg::OP_H};
  localparam logic [3:0] REF_KINDS   [2] = '{cpm_pkg::OP_D, cpm_pkg::OP_N};

  typedef struct {
    logic signed [16:0] value;
    logic               mapped;
    logic               overrun;
  } map_answer_t;

  // Tracks the map walk and holds the answers still owed by the block.
  class cigar_map_scoreboard;
    logic signed [16:0] map_words [cpm_pkg::MAP_DEPTH];
    int unsigned ref_cursor;
    int unsigned read_cursor;
    bit          overrun_seen;
    int unsigned align_start;
    int unsigned region_len_a;
    int unsigned region_len_b;
    bit          reverse_b;
    map_answer_t expected_answers [$];
    int failure_count;
    int answers_checked;
    int start_count;
    int op_count;
    int lookup_count;
    int mapped_count;

    function new();
      clear_map();
      ref_cursor   = 0;
      read_cursor  = 0;
      overrun_seen = 0;
      align_start  = 1;
      region_len_a = 0;
      region_len_b = 0;
      reverse_b    = 0;
    endfunction

    function void clear_map();
      foreach (map_words[i]) map_words[i] = -17'sd1;
    endfunction

    function int unsigned saturated_sum(int unsigned a, int unsigned b);
      return (a + b > CURSOR_MAX) ? CURSOR_MAX : a + b;
    endfunction

    function void write_register(logic [1:0] entry, logic [31:0] value);
      case (entry)
        cpm_pkg::REG_ALIGN_START:  align_start  = value[12:0];
        cpm_pkg::REG_REGION_LEN_A: region_len_a = value[12:0];
        cpm_pkg::REG_REGION_LEN_B: region_len_b = value[15:0];
        cpm_pkg::REG_REVERSE_B:    reverse_b    = value[0];
        default: ;
      endcase
    endfunction

    // Applies one accepted request and queues the answer it must produce.
    function void note_request(cpm_pkg::command_t cmd, logic [3:0] kind,
                               logic [15:0] len, logic [11:0] entry);
      map_answer_t ans;
      int unsigned limit;
      int unsigned stop;
      int unsigned p;
      int unsigned pos;
      int          stored;
      ans.value  = '0;
      ans.mapped = 1'b0;
      case (cmd)
        cpm_pkg::CMD_START: begin
          clear_map();
          ref_cursor   = (align_start > 0) ? align_start - 1 : 0;
          read_cursor  = 0;
          overrun_seen = 0;
          start_count++;
        end
        cpm_pkg::CMD_OP: begin
          op_count++;
          case (kind)
            cpm_pkg::OP_I, cpm_pkg::OP_S, cpm_pkg::OP_H: begin
              read_cursor = saturated_sum(read_cursor, len);
            end
            cpm_pkg::OP_D, cpm_pkg::OP_N: begin
              ref_cursor = saturated_sum(ref_cursor, len);
            end
            cpm_pkg::OP_M, cpm_pkg::OP_EQ, cpm_pkg::OP_X: begin
              if (len != 0) begin
                // Positions past the used region are dropped and flagged.
                limit = (region_len_a > cpm_pkg::MAP_DEPTH) ?
                        cpm_pkg::MAP_DEPTH : region_len_a;
                stop  = ref_cursor + len;
                if (stop > limit) overrun_seen = 1;
                for (p = ref_cursor; p < stop && p < limit; p++) begin
                  pos = read_cursor + (p - ref_cursor);
                  if (pos > VALUE_MAX) pos = VALUE_MAX;
                  map_words[p] = 17'(pos);
                end
                ref_cursor  = saturated_sum(ref_cursor, len);
                read_cursor = saturated_sum(read_cursor, len);
              end
            end
            default: ;
          endcase
        end
        cpm_pkg::CMD_READ: begin
          lookup_count++;
          stored = map_words[entry];
          if (stored >= 0) begin
            ans.mapped = 1'b1;
            ans.value  = reverse_b ? 17'(int'(region_len_b) - stored - 1) : 17'(stored);
            mapped_count++;
          end else begin
            ans.value = -17'sd1;
          end
        end
        default: ;
      endcase
      ans.overrun = overrun_seen;
      expected_answers.push_back(ans);
    endfunction

    // Compares one accepted result with the oldest owed answer.
    function void check_result(logic signed [16:0] value, logic mapped, logic ovr);
      map_answer_t want;
      answers_checked++;
      if (expected_answers.size() == 0) begin
        failure_count++;
        if (failure_count <= MAX_REPORTS)
          $display("ERROR at %0t: unexpected result map_value %0d is_mapped %0b overrun %0b",
                   $time, value, mapped, ovr);
        return;
      end
      want = expected_answers.pop_front();
      if (value !== want.value || mapped !== want.mapped || ovr !== want.overrun) begin
        failure_count++;
        if (failure_count <= MAX_REPORTS) begin
          $write("ERROR at %0t: result %0d: map_value exp %0d got %0d, ",
                 $time, answers_checked, want.value, value);
          $display("is_mapped exp %0b got %0b, overrun exp %0b got %0b",
                   want.mapped, mapped, want.overrun, ovr);
        end
      end
    endfunction

    function int close_out();
      if (expected_answers.size() != 0) begin
        $display("ERROR: %0d results never arrived", expected_answers.size());
        failure_count += expected_answers.size();
      end
      return failure_count;
    endfunction
  endclass

  logic        clk;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic [1:0]  command     = '0;
  logic [3:0]  op_kind     = '0;
  logic [15:0] op_len      = '0;
  logic [11:0] entry_index = '0;
  logic        out_ready   = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic        in_ready;
  logic        out_valid;
  logic signed [16:0] map_value;
  logic        is_mapped;
  logic        overrun;
  logic [31:0] prdata;
  logic        pready;

  cigar_map_scoreboard map_sb;
  int gap_pct    = 0;
  int stall_pct  = 0;
  int sent_count = 0;
  int stall_left = 0;

  cigar_position_map dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .op_kind     (op_kind),
    .op_len      (op_len),
    .entry_index (entry_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .map_value   (map_value),
    .is_mapped   (is_mapped),
    .overrun     (overrun),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Results are checked before new requests are noted, so a request taken
  // on this edge can never match a result leaving on the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) map_sb.check_result(map_value, is_mapped, overrun);
      if (in_valid && in_ready)
        map_sb.note_request(cpm_pkg::command_t'(command), op_kind, op_len, entry_index);
    end
  end

  // The result side stalls at random, in bursts of random length.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("ERROR: cycle limit of %0d reached", CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  task automatic apb_write(input logic [1:0] entry, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {entry, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    map_sb.write_register(entry, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_registers(input int unsigned align, input int unsigned len_a,
                                   input int unsigned len_b, input bit rev);
    apb_write(cpm_pkg::REG_ALIGN_START, align);
    apb_write(cpm_pkg::REG_REGION_LEN_A, len_a);
    apb_write(cpm_pkg::REG_REGION_LEN_B, len_b);
    apb_write(cpm_pkg::REG_REVERSE_B, 32'(rev));
  endtask

  // Picks a register setting, leaning toward the edges of each range.
  task automatic program_random_setting();
    int unsigned align;
    int unsigned len_a;
    int unsigned len_b;
    int r;
    r = $urandom_range(0, 99);
    if (r < 30)      align = $urandom_range(1, 32);
    else if (r < 60) align = $urandom_range(1, 4096);
    else if (r < 70) align = 0;
    else if (r < 80) align = 1;
    else if (r < 90) align = 4096;
    else             align = 8191;
    r = $urandom_range(0, 99);
    if (r < 25)      len_a = 4096;
    else if (r < 50) len_a = $urandom_range(0, 512);
    else if (r < 70) len_a = $urandom_range(0, 8191);
    else if (r < 80) len_a = 0;
    else if (r < 90) len_a = 8191;
    else             len_a = (align + $urandom_range(0, 64)) & 32'h1FFF;
    r = $urandom_range(0, 99);
    if (r < 20)      len_b = 0;
    else if (r < 40) len_b = 65535;
    else             len_b = $urandom_range(0, 65535);
    program_registers(align, len_a, len_b, 1'($urandom_range(0, 1)));
  endtask

  // Presents one request and holds it until the block takes it.
  task automatic send_request(input cpm_pkg::command_t cmd, input logic [3:0] kind,
                              input logic [15:0] len, input logic [11:0] entry);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    command     <= cmd;
    op_kind     <= kind;
    op_len      <= len;
    entry_index <= entry;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // Unused fields carry random values so their bits still toggle.
  task automatic send_start();
    send_request(cpm_pkg::CMD_START, 4'($urandom), 16'($urandom), 12'($urandom));
  endtask

  task automatic send_op(input logic [3:0] kind, input logic [15:0] len);
    send_request(cpm_pkg::CMD_OP, kind, len, 12'($urandom));
  endtask

  task automatic send_read(input logic [11:0] entry);
    send_request(cpm_pkg::CMD_READ, 4'($urandom), 16'($urandom), entry);
  endtask

  // Waits until every owed answer has come back and the block is quiet.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (map_sb.expected_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One alignment: a start followed by CIGAR operations mixed with lookups
  // near the start of the walk.
  task automatic run_walk();
    int steps;
    int r;
    int unsigned base;
    logic [3:0]  kind;
    logic [15:0] len;
    send_start();
    base  = (map_sb.align_start == 0) ? 0 : map_sb.align_start - 1;
    steps = $urandom_range(2, 10);
    repeat (steps) begin
      if ($urandom_range(0, 99) < 35) begin
        if ($urandom_range(0, 99) < 70) send_read(12'(base + $urandom_range(0, 63)));
        else                            send_read(12'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45)      kind = MATCH_KINDS[$urandom_range(0, 2)];
        else if (r < 70) kind = READ_KINDS[$urandom_range(0, 2)];
        else if (r < 88) kind = REF_KINDS[$urandom_range(0, 1)];
        else if (r < 94) kind = OP_P;
        else             kind = 4'($urandom_range(OP_UNKNOWN_LOW, OP_UNKNOWN_HIGH));
        // Mostly short runs; long runs are rare since the walk writes every base of the run.
        r = $urandom_range(0, 99);
        if (r < 88)      len = 16'($urandom_range(1, 24));
        else if (r < 97) len = 16'($urandom_range(0, 255));
        else             len = 16'($urandom);
        send_op(kind, len);
      end
    end
  endtask

  // Well-formed walks with some unstructured requests in between.
  task automatic run_mixed(input int quota);
    int target;
    target = sent_count + quota;
    while (sent_count < target) begin
      if ($urandom_range(0, 99) < 12)
        send_request(cpm_pkg::command_t'($urandom_range(0, 3)), 4'($urandom),
                     16'($urandom), 12'($urandom));
      else
        run_walk();
    end
  endtask

  // Many starts in a row on a tiny region, so that stale entries from
  // earlier walks must read as unmapped across the wrap of the start count.
  task automatic run_start_churn(input int starts);
    repeat (starts) begin
      send_start();
      if ($urandom_range(0, 99) < 40)
        send_op(MATCH_KINDS[$urandom_range(0, 2)], 16'($urandom_range(1, 8)));
      if ($urandom_range(0, 99) < 40) send_read(12'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    int phase;
    int errors;
    map_sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed walk over every operation on a 64-entry region.
    gap_pct   = 20;
    stall_pct = 20;
    program_registers(1, 64, 1000, 1'b0);
    send_read(12'd0);                      // Lookup before any start.
    send_start();
    send_op(cpm_pkg::OP_S, 16'd3);
    send_op(cpm_pkg::OP_H, 16'd2);
    send_op(cpm_pkg::OP_I, 16'd1);
    send_op(cpm_pkg::OP_M, 16'd4);
    send_op(cpm_pkg::OP_D, 16'd2);
    send_op(cpm_pkg::OP_N, 16'd1);
    send_op(cpm_pkg::OP_EQ, 16'd2);
    send_op(cpm_pkg::OP_X, 16'd1);
    send_op(OP_P, 16'd5);                  // Padding is ignored.
    send_op(OP_UNKNOWN_HIGH, 16'hFFFF);    // So is an unknown kind.
    send_op(cpm_pkg::OP_M, 16'd0);         // A zero-length match writes nothing.
    send_request(cpm_pkg::CMD_NONE, OP_UNKNOWN_HIGH, 16'hFFFF, 12'hFFF);
    send_read(12'd3);
    send_read(12'd9);
    send_op(cpm_pkg::OP_M, 16'd100);       // Runs past the end of the region.
    send_read(12'd63);
    send_read(12'hFFF);
    drain();

    // Directed saturation cases on the reversed strand, with a zero start.
    program_registers(0, 8191, 0, 1'b1);
    send_start();
    send_op(cpm_pkg::OP_M, 16'd1);
    send_read(12'd0);                      // Reversed value of minus one, still mapped.
    send_op(cpm_pkg::OP_I, 16'hFFFF);
    send_op(cpm_pkg::OP_I, 16'hFFFF);
    send_op(cpm_pkg::OP_M, 16'hFFFF);      // Fills the rest of the map with clipped values.
    send_read(12'hFFF);
    send_op(cpm_pkg::OP_D, 16'hFFFF);
    send_op(cpm_pkg::OP_N, 16'hFFFF);      // Reference cursor saturates.
    send_op(cpm_pkg::OP_X, 16'd1);
    drain();

    // Random phases; the last one runs without any idling.
    for (phase = 0; phase < 5; phase++) begin
      if (phase == 4) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = 10 * $urandom_range(0, 3);
        stall_pct = 10 * $urandom_range(0, 3);
      end
      case (phase)
        0: program_registers(4096, 4096, 65535, 1'b1);
        1: program_registers(8191, 8191, 0, 1'b0);
        2: program_registers(1, 16, $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
        default: program_random_setting();
      endcase
      case (phase)
        1: run_mixed(40);
        2: run_start_churn(260);
        default: run_mixed(phase == 0 ? 80 : 120);
      endcase
      drain();
    end

    errors = map_sb.close_out();
    $display("Covered %0d requests: %0d starts, %0d CIGAR ops, %0d lookups (%0d mapped).",
             sent_count, map_sb.start_count, map_sb.op_count, map_sb.lookup_count,
             map_sb.mapped_count);
    $display("Checked %0d results across seven register settings, %0d errors.",
             map_sb.answers_checked, errors);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
